// ===== rtl/core/plf_pkg.sv =====
package plf_pkg;

    // Design constants
    localparam int MAX_LEVEL   = 255;
    localparam int PIXEL_BYTES = 4;

    // Field widths
    localparam int PIX_W   = 32;
    localparam int LVL_W   = 8;
    localparam int SHIFT_W = $clog2(PIX_W);
    localparam int CNT_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = ADDR_W - 2;

    // Level saturation point as seen through an 8-bit level field
    localparam int LVL_CAP_I = (MAX_LEVEL > (2**LVL_W - 1)) ? (2**LVL_W - 1) : MAX_LEVEL;
    localparam logic [LVL_W-1:0] LVL_CAP = LVL_CAP_I[LVL_W-1:0];

    // Bytes that can be kept per pixel
    localparam int KEEP_BYTES_I = (PIXEL_BYTES < 4) ? PIXEL_BYTES : 4;
    localparam logic [CNT_W-1:0] KEEP_BYTES = KEEP_BYTES_I[CNT_W-1:0];

    // Exact floor division by MAX_LEVEL through a reciprocal multiply
    localparam int P_W   = PIX_W + LVL_W;
    localparam int PL_W  = P_W / 2;
    localparam int PH_W  = P_W - PL_W;
    localparam int DIV_L = $clog2(MAX_LEVEL);
    localparam int DIV_K = P_W + DIV_L;
    localparam int MG_W  = P_W + 1;
    localparam int ML_W  = (MG_W + 1) / 2;
    localparam int MH_W  = MG_W - ML_W;
    localparam int SUM_W = P_W + MG_W;
    localparam logic [63:0] DIV_MAGIC_64 =
        ((64'd1 << DIV_K) + 64'(MAX_LEVEL) - 64'd1) / 64'(MAX_LEVEL);
    localparam logic [MG_W-1:0] DIV_MAGIC = DIV_MAGIC_64[MG_W-1:0];

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RED_MASK   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_MASK = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLUE_MASK  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PIX_BYTES  = 3'd3;
    localparam logic [IDX_W-1:0] REG_COLOR_BYTES = 3'd4;

    // Register reset values
    localparam logic [PIX_W-1:0] RST_RED_MASK    = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_GREEN_MASK  = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_BLUE_MASK   = 32'h0000_00FF;
    localparam logic [CNT_W-1:0] RST_PIX_BYTES   = 3'd4;
    localparam logic [CNT_W-1:0] RST_COLOR_BYTES = 3'd3;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [PIX_W-1:0]   field;
        logic [PIX_W-1:0]   maxv;
    } chan_geom_t;

    typedef struct packed {
        chan_geom_t       red;
        chan_geom_t       green;
        chan_geom_t       blue;
        logic [PIX_W-1:0] color_keep;
        logic [PIX_W-1:0] pixel_keep;
    } shade_cfg_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

// ===== rtl/core/plf_cfg.sv =====
module plf_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plf_pkg::ADDR_W-1:0]  paddr,
    input  logic [plf_pkg::DATA_W-1:0]  pwdata,
    output logic [plf_pkg::DATA_W-1:0]  prdata,
    output plf_pkg::shade_cfg_t         cfg
);
    import plf_pkg::*;

    logic [PIX_W-1:0] red_mask_reg;
    logic [PIX_W-1:0] green_mask_reg;
    logic [PIX_W-1:0] blue_mask_reg;
    logic [CNT_W-1:0] pix_bytes_reg;
    logic [CNT_W-1:0] color_bytes_reg;
    shade_cfg_t       cfg_reg;
    shade_cfg_t       cfg_next;
    logic [IDX_W-1:0] reg_idx;
    logic             wr_en;

    // Shift, lowest run of ones and channel maximum of a field mask
    function automatic chan_geom_t geom_of(input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] low;
        logic [PIX_W:0]   carry_sum;
        chan_geom_t       g;
        low       = m & (~m + PIX_W'(1));
        carry_sum = {1'b0, m} + {1'b0, low};
        g.field   = m & ~carry_sum[PIX_W-1:0];
        g.shift   = '0;
        for (int b = 0; b < PIX_W; b++)
        begin
            if (low[b])
            begin
                g.shift = g.shift | SHIFT_W'(b);
            end
        end
        g.maxv = g.field >> g.shift;
        return g;
    endfunction

    // Low-byte keep mask for a byte count
    function automatic logic [PIX_W-1:0] byte_keep(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        logic [PIX_W-1:0] keep;
        n = (count > KEEP_BYTES) ? KEEP_BYTES : count;
        for (int b = 0; b < PIX_W / 8; b++)
        begin
            keep[8*b +: 8] = (CNT_W'(b) < n) ? 8'hFF : 8'h00;
        end
        return keep;
    endfunction

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg    <= RST_RED_MASK;
            green_mask_reg  <= RST_GREEN_MASK;
            blue_mask_reg   <= RST_BLUE_MASK;
            pix_bytes_reg   <= RST_PIX_BYTES;
            color_bytes_reg <= RST_COLOR_BYTES;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RED_MASK:    red_mask_reg    <= pwdata[PIX_W-1:0];
                REG_GREEN_MASK:  green_mask_reg  <= pwdata[PIX_W-1:0];
                REG_BLUE_MASK:   blue_mask_reg   <= pwdata[PIX_W-1:0];
                REG_PIX_BYTES:   pix_bytes_reg   <= pwdata[CNT_W-1:0];
                REG_COLOR_BYTES: color_bytes_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register values on read
    always_comb
    begin
        case (reg_idx)
            REG_RED_MASK:    prdata = DATA_W'(red_mask_reg);
            REG_GREEN_MASK:  prdata = DATA_W'(green_mask_reg);
            REG_BLUE_MASK:   prdata = DATA_W'(blue_mask_reg);
            REG_PIX_BYTES:   prdata = DATA_W'(pix_bytes_reg);
            REG_COLOR_BYTES: prdata = DATA_W'(color_bytes_reg);
            default:         prdata = '0;
        endcase
    end

    // Decode channel geometry and byte masks into a register that follows the config registers in the next cycle
    always_comb
    begin
        cfg_next.red        = geom_of(red_mask_reg);
        cfg_next.green      = geom_of(green_mask_reg);
        cfg_next.blue       = geom_of(blue_mask_reg);
        cfg_next.color_keep = byte_keep(color_bytes_reg);
        cfg_next.pixel_keep = byte_keep(pix_bytes_reg);
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/plf_chan.sv =====
module plf_chan
(
    input  logic                       clk,
    input  plf_pkg::stage_en_t         en,
    input  plf_pkg::chan_geom_t        geom,
    input  logic [plf_pkg::PIX_W-1:0]  color,
    input  logic                       fog,
    input  logic [plf_pkg::LVL_W-1:0]  lvl,
    output logic [plf_pkg::PIX_W-1:0]  shaded
);
    import plf_pkg::*;

    logic [PIX_W-1:0]      c_in;
    logic [PIX_W-1:0]      a_next;
    logic [PIX_W-1:0]      a_reg;
    logic [PIX_W-1:0]      c2_reg;
    logic                  fog2_reg;
    logic [LVL_W-1:0]      lvl2_reg;
    logic [P_W-1:0]        p_reg;
    logic [PIX_W-1:0]      c3_reg;
    logic                  fog3_reg;
    logic [PL_W+ML_W-1:0]  pp_ll_reg;
    logic [PL_W+MH_W-1:0]  pp_lh_reg;
    logic [PH_W+ML_W-1:0]  pp_hl_reg;
    logic [PH_W+MH_W-1:0]  pp_hh_reg;
    logic [PIX_W-1:0]      c4_reg;
    logic                  fog4_reg;
    logic [SUM_W-1:0]      prod_sum;
    logic [PIX_W-1:0]      q_reg;
    logic [PIX_W-1:0]      c5_reg;
    logic                  fog5_reg;
    logic [PIX_W-1:0]      value;

    // Extract the channel and pick the scaled operand
    assign c_in   = (color & geom.field) >> geom.shift;
    assign a_next = fog ? (geom.maxv - c_in) : c_in;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            a_reg    <= a_next;
            c2_reg   <= c_in;
            fog2_reg <= fog;
            lvl2_reg <= lvl;
        end
    end

    // Multiply operand by level
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            p_reg    <= P_W'(a_reg) * P_W'(lvl2_reg);
            c3_reg   <= c2_reg;
            fog3_reg <= fog2_reg;
        end
    end

    // Form partial products against the reciprocal
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pp_ll_reg <= (PL_W+ML_W)'(p_reg[PL_W-1:0]) * (PL_W+ML_W)'(DIV_MAGIC[ML_W-1:0]);
            pp_lh_reg <= (PL_W+MH_W)'(p_reg[PL_W-1:0]) * (PL_W+MH_W)'(DIV_MAGIC[MG_W-1:ML_W]);
            pp_hl_reg <= (PH_W+ML_W)'(p_reg[P_W-1:PL_W]) * (PH_W+ML_W)'(DIV_MAGIC[ML_W-1:0]);
            pp_hh_reg <= (PH_W+MH_W)'(p_reg[P_W-1:PL_W]) * (PH_W+MH_W)'(DIV_MAGIC[MG_W-1:ML_W]);
            c4_reg    <= c3_reg;
            fog4_reg  <= fog3_reg;
        end
    end

    // Sum partial products; the quotient sits above the reciprocal's scale
    assign prod_sum = (SUM_W'(pp_hh_reg) << (PL_W + ML_W))
                    + (SUM_W'(pp_hl_reg) << PL_W)
                    + (SUM_W'(pp_lh_reg) << ML_W)
                    + SUM_W'(pp_ll_reg);

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            q_reg    <= PIX_W'(prod_sum >> DIV_K);
            c5_reg   <= c4_reg;
            fog5_reg <= fog4_reg;
        end
    end

    // Blend toward max in fog mode and move back to the field position
    assign value  = fog5_reg ? (c5_reg + q_reg) : q_reg;
    assign shaded = value << geom.shift;

endmodule

// ===== rtl/core/pixel_light_fog_shader_unit.sv =====
// Pixel light / fog shader.
// Input stream: one word per pixel. s_axis_tdata carries the packed pixel
// and an intensity level, s_axis_tuser selects light (0) or fog (1).
// Output stream: one shaded pixel word per input word, in order.
// Each channel is found through its field mask (shift = trailing zeros,
// max = 2^run - 1). Light scales c*level/MAX_LEVEL, fog gives
// c + level*(max-c)/MAX_LEVEL, both rounded down; bytes above the pixel
// byte count are zero.
// The APB port holds the three field masks and the two byte counts;
// write them only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver is ready. A pixel goes from the input
// handshake to m_axis_tvalid through the six register stages (input,
// operand, level product, reciprocal partial products, quotient, output).
// Reset clears all stage valids and loads the register defaults.
// When the receiver stalls, the pipeline fills up its empty stages and
// then drops s_axis_tready; the held output word stays stable.
module pixel_light_fog_shader_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [39:0]                 s_axis_tdata,  // [31:0] pixel_in, [39:32] level
    input  logic                        s_axis_tuser,  // [0] func
    // Output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // [31:0] pixel_out
    // Configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plf_pkg::ADDR_W-1:0]  paddr,
    input  logic [plf_pkg::DATA_W-1:0]  pwdata,
    output logic [plf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import plf_pkg::*;

    shade_cfg_t       cfg;
    stage_en_t        en;
    logic             en1;
    logic             en_out;
    logic             s_acc;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             v4_reg;
    logic             v5_reg;
    logic             vo_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic [LVL_W-1:0] lvl1_reg;
    logic             fog1_reg;
    logic [LVL_W-1:0] lvl_in;
    logic [PIX_W-1:0] color1;
    logic [PIX_W-1:0] red_val;
    logic [PIX_W-1:0] green_val;
    logic [PIX_W-1:0] blue_val;
    logic [PIX_W-1:0] out_next;
    logic [PIX_W-1:0] out_reg;

    assign pready = 1'b1;

    plf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Advance each stage when it is empty or the next one advances
    assign en_out = !vo_reg || m_axis_tready;
    assign en.s5  = !v5_reg || en_out;
    assign en.s4  = !v4_reg || en.s5;
    assign en.s3  = !v3_reg || en.s4;
    assign en.s2  = !v2_reg || en.s3;
    assign en1    = !v1_reg || en.s2;

    assign s_axis_tready = en1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (en.s5)
            begin
                v5_reg <= v4_reg;
            end
            if (en_out)
            begin
                vo_reg <= v5_reg;
            end
        end
    end

    // Capture the input word, saturating the level
    assign lvl_in = (s_axis_tdata[39:32] > LVL_CAP) ? LVL_CAP : s_axis_tdata[39:32];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pix1_reg <= s_axis_tdata[31:0];
            lvl1_reg <= lvl_in;
            fog1_reg <= s_axis_tuser;
        end
    end

    // Keep only the color bytes
    assign color1 = pix1_reg & cfg.color_keep;

    plf_chan u_red
    (
        .clk    (clk),
        .en     (en),
        .geom   (cfg.red),
        .color  (color1),
        .fog    (fog1_reg),
        .lvl    (lvl1_reg),
        .shaded (red_val)
    );

    plf_chan u_green
    (
        .clk    (clk),
        .en     (en),
        .geom   (cfg.green),
        .color  (color1),
        .fog    (fog1_reg),
        .lvl    (lvl1_reg),
        .shaded (green_val)
    );

    plf_chan u_blue
    (
        .clk    (clk),
        .en     (en),
        .geom   (cfg.blue),
        .color  (color1),
        .fog    (fog1_reg),
        .lvl    (lvl1_reg),
        .shaded (blue_val)
    );

    // Repack channels and clear bytes above the pixel size
    assign out_next = (red_val | green_val | blue_val) & cfg.pixel_keep;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = out_reg;

    // A ready receiver never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // With the receiver ready throughout, an accepted word is offered at the output and not lost in the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(s_acc, 6) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
         && $past(m_axis_tready, 3) && $past(m_axis_tready, 4)
         && $past(m_axis_tready, 5)
         && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
         && $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6)) |-> m_axis_tvalid)
        else $error("word lost in the shading pipeline");

    // Light mode at level zero gives a black pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(s_acc && !s_axis_tuser && (s_axis_tdata[39:32] == 8'd0), 6)
         && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
         && $past(m_axis_tready, 3) && $past(m_axis_tready, 4)
         && $past(m_axis_tready, 5)
         && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
         && $past(rst_n, 4) && $past(rst_n, 5) && $past(rst_n, 6))
        |-> (m_axis_tdata == '0))
        else $error("light at level zero not black");

endmodule

// ===== tb/tb_pixel_light_fog_shader_unit.sv =====
`timescale 1ns / 100ps

module tb_pixel_light_fog_shader_unit;

    import plf_pkg::*;

    localparam logic FUNC_LIGHT = 1'b0;
    localparam logic FUNC_FOG   = 1'b1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [PIX_W-1:0] pixel_out;
        logic             func;
        logic [PIX_W-1:0] pixel_in;
        logic [LVL_W-1:0] level;
    } shaded_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata = '0;  // [31:0] pixel_in, [39:32] level
    logic                s_axis_tuser = 1'b0; // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;        // [31:0] pixel_out
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the configuration registers
    logic [PIX_W-1:0]    cfg_red_mask    = RST_RED_MASK;
    logic [PIX_W-1:0]    cfg_green_mask  = RST_GREEN_MASK;
    logic [PIX_W-1:0]    cfg_blue_mask   = RST_BLUE_MASK;
    logic [CNT_W-1:0]    cfg_pixel_bytes = RST_PIX_BYTES;
    logic [CNT_W-1:0]    cfg_color_bytes = RST_COLOR_BYTES;

    shaded_word_t        pending_pixels[$];
    shaded_word_t        oldest_pixel;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  ready_stall_left = 0;
    bit                  idle_on = 1'b1;

    pixel_light_fog_shader_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mask of the low bytes that a byte count keeps
    function automatic logic [PIX_W-1:0] byte_keep_mask(logic [CNT_W-1:0] count);
        int          n;
        logic [63:0] m;
        n = count;
        if (n > 4)
            n = 4;
        if (n > PIXEL_BYTES)
            n = PIXEL_BYTES;
        if (n == 0)
            m = 64'd0;
        else
            m = (64'd1 << (8 * n)) - 64'd1;
        return m[PIX_W-1:0];
    endfunction

    // Shade one channel: decode at the mask's lowest run of ones, scale, repack
    function automatic logic [PIX_W-1:0] shade_field(logic [PIX_W-1:0] color,
                                                     logic [PIX_W-1:0] mask,
                                                     logic fog, logic [63:0] lvl);
        int          lsb;
        int          run;
        bit          in_run;
        logic [63:0] top;
        logic [63:0] c;
        logic [63:0] v;
        lsb = 0;
        run = 0;
        top = 64'd0;
        if (mask != '0)
        begin
            while (mask[lsb] == 1'b0)
                lsb++;
            in_run = 1'b1;
            for (int b = lsb; b < PIX_W; b++)
            begin
                if (in_run && mask[b])
                    run++;
                else
                    in_run = 1'b0;
            end
            top = (64'd1 << run) - 64'd1;
        end
        c = (64'(color & mask) >> lsb) & top;
        if (fog)
            v = c + (lvl * (top - c)) / 64'(MAX_LEVEL);
        else
            v = (c * lvl) / 64'(MAX_LEVEL);
        v = v << lsb;
        return v[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] shade_pixel(logic func, logic [PIX_W-1:0] pixel,
                                                     logic [LVL_W-1:0] level);
        logic [63:0]      lvl;
        logic [PIX_W-1:0] color;
        logic [PIX_W-1:0] res;
        lvl = 64'(level);
        if (lvl > 64'(MAX_LEVEL))
            lvl = 64'(MAX_LEVEL);
        color = pixel & byte_keep_mask(cfg_color_bytes);
        res = shade_field(color, cfg_red_mask, func == FUNC_FOG, lvl)
            | shade_field(color, cfg_green_mask, func == FUNC_FOG, lvl)
            | shade_field(color, cfg_blue_mask, func == FUNC_FOG, lvl);
        return res & byte_keep_mask(cfg_pixel_bytes);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp, logic [31:0] got);
        $display("cycle %0d: %s: expected %08h got %08h", cycle_count, what, exp, got);
        error_count++;
    endtask

    // Compare each output word with the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("output word with none pending", 32'd0, m_axis_tdata);
            else
            begin
                oldest_pixel = pending_pixels.pop_front();
                if (m_axis_tdata !== oldest_pixel.pixel_out)
                    report_mismatch($sformatf("pixel_out (func %0d pixel %08h level %0d)",
                                              oldest_pixel.func, oldest_pixel.pixel_in,
                                              oldest_pixel.level),
                                    oldest_pixel.pixel_out, m_axis_tdata);
            end
        end
    end

    // Stall the output side in random bursts
    always @(posedge clk)
    begin
        if (ready_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall_left <= ready_stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall_left <= $urandom_range(0, 18);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Offer one pixel word, hold until taken, then record its expected result
    task automatic send_pixel(logic func, logic [PIX_W-1:0] pixel, logic [LVL_W-1:0] level);
        shaded_word_t item;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {level, pixel};
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        item.pixel_out = shade_pixel(func, pixel, level);
        item.func      = func;
        item.pixel_in  = pixel;
        item.level     = level;
        pending_pixels.push_back(item);
    endtask

    task automatic send_random_pixel();
        logic [LVL_W-1:0] level;
        case ($urandom_range(0, 7))
            0:       level = '0;
            1:       level = '1;
            default: level = LVL_W'($urandom_range(0, 255));
        endcase
        send_pixel(1'($urandom_range(0, 1)), $urandom, level);
    endtask

    // Drop valid and let the pipeline empty out
    task automatic wait_pipeline_empty();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup phase, access phase until pready, then back to idle
    task automatic write_register(logic [IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_RED_MASK:    cfg_red_mask    = value;
            REG_GREEN_MASK:  cfg_green_mask  = value;
            REG_BLUE_MASK:   cfg_blue_mask   = value;
            REG_PIX_BYTES:   cfg_pixel_bytes = value[CNT_W-1:0];
            REG_COLOR_BYTES: cfg_color_bytes = value[CNT_W-1:0];
            default:         ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_setup(logic [31:0] red, logic [31:0] green, logic [31:0] blue,
                               logic [31:0] pix_bytes, logic [31:0] color_bytes);
        write_register(REG_RED_MASK, red);
        write_register(REG_GREEN_MASK, green);
        write_register(REG_BLUE_MASK, blue);
        write_register(REG_PIX_BYTES, pix_bytes);
        write_register(REG_COLOR_BYTES, color_bytes);
    endtask

    function automatic logic [31:0] random_field_mask();
        int          width;
        logic [63:0] m;
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default:
            begin
                width = $urandom_range(1, 32);
                m = ((64'd1 << width) - 64'd1) << $urandom_range(0, 32 - width);
                return m[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] random_byte_count();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 7);
        return $urandom_range(1, 4);
    endfunction

    // Reset defaults: 8-8-8 layout, extremes of pixel and level, both operations
    task automatic test_default_setup();
        send_pixel(FUNC_LIGHT, 32'h0000_0000, 8'd0);
        send_pixel(FUNC_FOG,   32'h0000_0000, 8'd255);
        send_pixel(FUNC_LIGHT, 32'hFFFF_FFFF, 8'd255);
        send_pixel(FUNC_FOG,   32'hFFFF_FFFF, 8'd0);
        send_pixel(FUNC_LIGHT, 32'h12AB_CDEF, 8'd128);
        send_pixel(FUNC_FOG,   32'h8040_2010, 8'd127);
        send_pixel(FUNC_LIGHT, 32'hFF80_7F01, 8'd1);
        send_pixel(FUNC_FOG,   32'h0055_AA33, 8'd254);
        wait_pipeline_empty();
    endtask

    // Zero, split, overlapping and full masks; byte counts of zero and above four
    task automatic test_field_corner_cases();
        write_setup(32'h0, 32'h0000_FF00, 32'h0000_00F5, 4, 3);
        send_pixel(FUNC_FOG,   32'hFFFF_FFFF, 8'd128);
        send_pixel(FUNC_LIGHT, 32'h00AB_CDEF, 8'd200);
        wait_pipeline_empty();

        write_setup(32'h0000_0FF0, 32'h0000_00FF, 32'h0000_FFFF, 2, 1);
        send_pixel(FUNC_FOG,   32'hA5A5_A5A5, 8'd90);
        send_pixel(FUNC_LIGHT, 32'hFFFF_FFFF, 8'd255);
        wait_pipeline_empty();

        write_setup(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 7, 5);
        send_pixel(FUNC_FOG,   32'hFFFF_FFFF, 8'd255);
        send_pixel(FUNC_LIGHT, 32'h89AB_CDEF, 8'd77);
        send_pixel(FUNC_FOG,   32'h1234_5678, 8'd1);
        wait_pipeline_empty();

        write_setup(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 0, 4);
        send_pixel(FUNC_FOG, 32'hFFFF_FFFF, 8'd200);
        wait_pipeline_empty();
        write_register(REG_PIX_BYTES, 4);
        write_register(REG_COLOR_BYTES, 0);
        send_pixel(FUNC_FOG, 32'hFFFF_FFFF, 8'd100);
        wait_pipeline_empty();

        // 5-6-5 layout in two bytes
        write_setup(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 2, 2);
        send_pixel(FUNC_LIGHT, 32'hDEAD_BEEF, 8'd170);
        send_pixel(FUNC_FOG,   32'h0000_1234, 8'd33);
        wait_pipeline_empty();
    endtask

    // Random layouts, each with a burst of random pixels
    task automatic test_random_setups();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_setup(random_field_mask(), random_field_mask(), random_field_mask(),
                        random_byte_count(), random_byte_count());
            for (int i = 0; i < 60; i++)
            begin
                // Hold off the sender until the pipeline has emptied once
                if (phase == 3 && i == 30)
                    wait_pipeline_empty();
                send_random_pixel();
            end
            wait_pipeline_empty();
        end
    endtask

    // Full-rate stream with no idling on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        write_setup(RST_RED_MASK, RST_GREEN_MASK, RST_BLUE_MASK,
                    32'(RST_PIX_BYTES), 32'(RST_COLOR_BYTES));
        for (int i = 0; i < 100; i++)
            send_random_pixel();
        wait_pipeline_empty();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_setup();
        test_field_corner_cases();
        test_random_setups();
        test_back_to_back();
        wait_pipeline_empty();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
